FILE: design/assert_macros.svh
// assertion macros used by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define UER_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition in one cycle forces a condition in the next
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/uer_pkg.sv
// types, codes and constants of the ultrasonic echo ranger
package uer_pkg;

  localparam int NUM_SENSORS_DEF = 3;

  // distance = (pulse * DIST_MUL) >> DIST_SHIFT, 1/256 cm
  localparam int MUL_W      = 13;
  localparam logic [MUL_W-1:0] DIST_MUL = 13'd4496;
  localparam int DIST_SHIFT = 10;
  localparam int TIME_W     = 32;
  localparam int DIST_W     = 23;
  localparam int TMO_W      = 20;
  localparam int PROD_W     = TIME_W + MUL_W;

  // result queue depth, covers the items in flight
  localparam int OUT_DEPTH  = 4;

  // apb port
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  typedef enum logic [1:0] {
    OP_TRIGGER = 2'd0,
    OP_EDGE    = 2'd1,
    OP_EVAL    = 2'd2
  } op_e_t;

  typedef enum logic [1:0] {
    ST_ACCEPT   = 2'd0,
    ST_NO_PULSE = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_MIN     = 2'd1,
    REG_MAX     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        sensor;
    logic              level;
    logic [TIME_W-1:0] time_us;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        sensor_out;
    logic [1:0]        status;
    logic [DIST_W-1:0] measured;
    logic [DIST_W-1:0] filtered;
    logic              valid_res;
  } result_t;

  // one sensor's state, one memory word
  typedef struct packed {
    logic [TIME_W-1:0] echo_start;
    logic [TIME_W-1:0] pulse_width;
    logic              waiting_fall;
    logic              pulse_ready;
    logic [DIST_W-1:0] smoothed;
    logic              has_reading;
  } entry_t;

endpackage

FILE: design/ultrasonic_echo_ranging.sv
// ultrasonic echo ranger top level: per-sensor state memory and result queue
//
//  channel   dir  handshake                    payload
//  cmd       in   cmd_valid / cmd_stall        uer_pkg::cmd_t (op, sensor, level, time_us)
//  result    out  result_valid / result_stall  uer_pkg::result_t
//  apb       in   psel penable pwrite pready   paddr, pwdata, prdata
//
// one item per cycle while cmd_stall is low; an evaluate item's result goes through
// memory read, multiply stage, update stage and result queue, the read-modify-write
// pipe around the sensor state memory
// cmd_stall rises only when the result queue plus evaluations in flight fill
// its OUT_DEPTH entries, so it follows registered state only
// reset is synchronous: sensor entries read as zero until first written
// (one valid flop per sensor), registers return to their defaults
`include "assert_macros.svh"

module ultrasonic_echo_ranging #(
  parameter int NUM_SENSORS = uer_pkg::NUM_SENSORS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  uer_pkg::cmd_t                cmd,
  output logic                         result_valid,
  input  logic                         result_stall,
  output uer_pkg::result_t             result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [uer_pkg::PADDR_W-1:0]  paddr,
  input  logic [uer_pkg::PDATA_W-1:0]  pwdata,
  output logic [uer_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import uer_pkg::*;

  localparam int AW    = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  // configuration registers
  logic [TMO_W-1:0]  timeout_us;
  logic [DIST_W-1:0] min_distance;
  logic [DIST_W-1:0] max_distance;
  logic              cfg_wr;

  // sensor state memory
  entry_t            mem [NUM_SENSORS];
  entry_t            mem_q;
  logic              entry_valid [NUM_SENSORS];
  logic              rd_valid;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  // input decode
  logic              cmd_acc;
  logic              cmd_ok;

  // stage 1: forwarded entry, multiply and timeout check
  logic              s1_valid;
  cmd_t              s1_cmd;
  logic [AW-1:0]     s1_addr;
  entry_t            s1_cur;
  logic [TIME_W-1:0] s1_diff;
  logic [PROD_W-1:0] s1_prod;
  logic              s1_over;

  // stage 2: range check, smoothing, write back
  logic              s2_valid;
  cmd_t              s2_cmd;
  logic [AW-1:0]     s2_addr;
  entry_t            s2_cur;
  logic [TIME_W-1:0] s2_diff;
  logic [PROD_W-1:0] s2_prod;
  logic              s2_over;
  entry_t            s2_next;
  result_t           s2_res;
  logic [DIST_W-1:0] s2_dist;
  logic [DIST_W:0]   s2_sum;

  // last write, for the read that raced it
  logic              wb_valid;
  logic [AW-1:0]     wb_addr;
  entry_t            wb_entry;

  // result queue
  result_t           fifo_mem [OUT_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fifo_count;
  logic              push;
  logic              pop;
  logic              s1_eval;
  logic              s2_eval;
  logic [CNT_W:0]    credit_used;

  // ---------------------------------------------------------------- apb
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us   <= TMO_W'(30000);
      min_distance <= DIST_W'(512);
      max_distance <= DIST_W'(102400);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TIMEOUT: timeout_us   <= pwdata[TMO_W-1:0];
        REG_MIN:     min_distance <= pwdata[DIST_W-1:0];
        REG_MAX:     max_distance <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TIMEOUT: prdata = PDATA_W'(timeout_us);
      REG_MIN:     prdata = PDATA_W'(min_distance);
      REG_MAX:     prdata = PDATA_W'(max_distance);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input
  assign s1_eval     = s1_valid && (s1_cmd.op == OP_EVAL);
  assign s2_eval     = s2_valid && (s2_cmd.op == OP_EVAL);
  assign credit_used = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(s1_eval) + (CNT_W+1)'(s2_eval);
  // hold off while every queue slot is spoken for
  assign cmd_stall   = credit_used >= (CNT_W+1)'(OUT_DEPTH);
  assign cmd_acc     = cmd_valid && !cmd_stall;

  // unused op code and absent sensor are dropped here
  assign cmd_ok  = ({30'd0, cmd.sensor} < 32'(NUM_SENSORS)) &&
                   (cmd.op == OP_TRIGGER || cmd.op == OP_EDGE || cmd.op == OP_EVAL);
  assign rd_en   = cmd_acc && cmd_ok;
  assign rd_addr = AW'(cmd.sensor);

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      rd_valid <= entry_valid[rd_addr];
    end
    if (s2_valid) begin
      mem[s2_addr] <= s2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        entry_valid[i] <= 1'b0;
      end
    end else if (s2_valid) begin
      entry_valid[s2_addr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_cmd  <= cmd;
      s1_addr <= rd_addr;
    end
  end

  // newest copy wins: update stage, then last write, then memory
  always_comb begin
    if (s2_valid && (s2_addr == s1_addr)) begin
      s1_cur = s2_next;
    end else if (wb_valid && (wb_addr == s1_addr)) begin
      s1_cur = wb_entry;
    end else if (rd_valid) begin
      s1_cur = mem_q;
    end else begin
      s1_cur = '0;
    end
  end

  assign s1_diff = s1_cmd.time_us - s1_cur.echo_start;
  assign s1_prod = PROD_W'(s1_cur.pulse_width) * PROD_W'(DIST_MUL);
  assign s1_over = s1_cur.pulse_width > TIME_W'(timeout_us);

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_cmd  <= s1_cmd;
      s2_addr <= s1_addr;
      s2_cur  <= s1_cur;
      s2_diff <= s1_diff;
      s2_prod <= s1_prod;
      s2_over <= s1_over;
    end
  end

  assign s2_dist = s2_prod[DIST_SHIFT +: DIST_W];
  assign s2_sum  = {1'b0, s2_cur.smoothed} + {1'b0, s2_dist};

  always_comb begin
    s2_next            = s2_cur;
    s2_res.sensor_out  = s2_cmd.sensor;
    s2_res.status      = ST_ACCEPT;
    s2_res.measured    = '0;
    unique case (s2_cmd.op)
      OP_TRIGGER: begin
        s2_next.pulse_ready  = 1'b0;
        s2_next.waiting_fall = 1'b0;
      end
      OP_EDGE: begin
        if (s2_cmd.level) begin
          // rising edge, also restarts a pending measurement
          s2_next.echo_start   = s2_cmd.time_us;
          s2_next.waiting_fall = 1'b1;
        end else if (s2_cur.waiting_fall) begin
          s2_next.pulse_width  = s2_diff;
          s2_next.waiting_fall = 1'b0;
          s2_next.pulse_ready  = 1'b1;
        end
      end
      OP_EVAL: begin
        if (!s2_cur.pulse_ready) begin
          s2_res.status = ST_NO_PULSE;
        end else begin
          s2_next.pulse_ready = 1'b0;
          if (s2_over) begin
            s2_res.status = ST_TIMEOUT;
          end else begin
            s2_res.measured = s2_dist;
            if ((s2_dist < min_distance) || (s2_dist > max_distance)) begin
              s2_res.status = ST_RANGE;
            end else begin
              // first reading loads, later ones average half and half
              s2_next.smoothed    = s2_cur.has_reading ? s2_sum[DIST_W:1] : s2_dist;
              s2_next.has_reading = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    s2_res.filtered  = s2_next.smoothed;
    s2_res.valid_res = s2_next.has_reading;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      wb_addr  <= s2_addr;
      wb_entry <= s2_next;
    end
  end

  // ---------------------------------------------------------------- result queue
  assign push         = s2_eval;
  assign result_valid = fifo_count != '0;
  assign pop          = result_valid && !result_stall;
  assign result       = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= s2_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fifo_count <= fifo_count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // ---------------------------------------------------------------- checks
  `UER_ASSERT(a_credit_bound, credit_used <= (CNT_W+1)'(OUT_DEPTH), "result credit overrun")
  `UER_ASSERT_NEXT(a_push_lands, push, fifo_count != '0, "pushed result missing from queue")
  `UER_ASSERT(a_accept_has_reading,
    !(result_valid && (result.status == ST_ACCEPT)) || result.valid_res,
    "accepted result without reading")

endmodule
